/* rtl/fpfl_pkg.sv */
`timescale 1ns / 1ps

package fpfl_pkg;

    localparam int CNT_W     = 11;   // pool_count, used and fresh counters
    localparam int IDX_W     = 10;   // slot index on the ports
    localparam int OFS_W     = 22;   // byte offset
    localparam int ESZ_W     = 13;   // element_size
    localparam int ALN_W     = 4;    // alignment_log2
    localparam int SB_W      = 17;   // rounded slot size in bytes
    localparam int CFG_W     = 13;   // widest config register
    localparam int CFG_IDX_W = 2;

    localparam int IN_DATA_W  = 16;  // slot_index, zero filled
    localparam int OUT_DATA_W = 48;  // granted_index, byte_offset, used_count

    localparam logic [CNT_W-1:0] POOL_COUNT_RST = 11'd1024;
    localparam logic [ESZ_W-1:0] ELEM_SIZE_RST  = 13'd8;
    localparam logic [ALN_W-1:0] ALIGN_LOG2_RST = 4'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_COUNT = 2'd0,
        CFG_ELEM_SIZE  = 2'd1,
        CFG_ALIGN_LOG2 = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NONE_USED = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

endpackage

/* rtl/fpfl_ram.sv */
`timescale 1ns / 1ps

module fpfl_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/fixed_pool_free_list_allocator_unit.sv */
`timescale 1ns / 1ps

// Fixed-size slot pool with a LIFO free list kept as next-slot links in one
// synchronous RAM. Requests come in one at a time: a release or an allocate
// from never-used slots goes from S_IDLE to S_MUL, which loads its result once
// the output register is free; an allocate that pops the free list passes
// through S_POP first, for the link RAM read of the head slot. The byte
// offset is computed in the cycle that ends with the result register load. A
// finished result waits in the output register, so the next request can be
// accepted while it is still pending. Writing pool_count
// restarts the pool empty without clearing the RAM; element_size and
// alignment_log2 take effect on the next offset.
module fixed_pool_free_list_allocator_unit #(
    parameter int POOL_SLOTS    = 1024,
    parameter int POINTER_BYTES = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // config write port
    input  logic                                  i_cfg_we,
    input  logic [fpfl_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [fpfl_pkg::CFG_W-1:0]            i_cfg_data,
    // request stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [fpfl_pkg::IN_DATA_W-1:0]        s_axis_tdata,  // [9:0] slot_index
    input  logic                                  s_axis_tuser,  // [0] opcode
    // result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [9:0] granted_index, [31:10] byte_offset, [42:32] used_count
    output logic [fpfl_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    output logic [1:0]                            m_axis_tuser   // [1:0] status
);

    import fpfl_pkg::*;

    localparam int AW = $clog2(POOL_SLOTS > 1 ? POOL_SLOTS : 2);
    localparam int LW = $clog2(POOL_SLOTS + 1);
    localparam int PW = AW + SB_W;
    localparam logic [LW-1:0] LINK_END = LW'(POOL_SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_MUL
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_pool_count;
    logic [ESZ_W-1:0]  r_elem_size;
    logic [ALN_W-1:0]  r_align_log2;
    logic [AW-1:0]     r_head, n_head;
    logic              r_head_valid, n_head_valid;
    logic [CNT_W-1:0]  r_fresh, n_fresh;
    logic [CNT_W-1:0]  r_in_use, n_in_use;
    logic [AW-1:0]     r_slot, n_slot;
    t_status           r_status, n_status;
    logic              r_out_valid, n_out_valid;
    logic [IDX_W-1:0]  r_out_index, n_out_index;
    logic [OFS_W-1:0]  r_out_offset, n_out_offset;
    logic [CNT_W-1:0]  r_out_used, n_out_used;
    t_status           r_out_status, n_out_status;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [LW-1:0]     mem_wdata;
    logic              mem_re;
    logic [LW-1:0]     mem_rdata;

    logic              in_acc;
    t_op               in_op;
    logic [IDX_W-1:0]  in_idx;
    logic [CNT_W-1:0]  eff_count;
    logic [ESZ_W-1:0]  elem_min;
    logic [SB_W-1:0]   align_mask;
    logic [SB_W-1:0]   slot_bytes;
    logic [PW-1:0]     slot_ofs;
    logic              cfg_restart;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign in_op  = t_op'(s_axis_tuser);
    assign in_idx = s_axis_tdata[IDX_W-1:0];

    assign eff_count  = (32'(r_pool_count) > POOL_SLOTS) ? CNT_W'(POOL_SLOTS) : r_pool_count;
    assign elem_min   = (32'(r_elem_size) < POINTER_BYTES) ? ESZ_W'(POINTER_BYTES)
                                                           : r_elem_size;
    assign align_mask = (SB_W'(1) << r_align_log2) - SB_W'(1);
    assign slot_bytes = (SB_W'(elem_min) + align_mask) & ~align_mask;
    assign slot_ofs   = PW'(r_slot) * PW'(slot_bytes);
    assign cfg_restart = i_cfg_we && (t_cfg_idx'(i_cfg_index) == CFG_POOL_COUNT);

    fpfl_ram #(
        .WIDTH (LW),
        .DEPTH (POOL_SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_head),
        .o_rdata (mem_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {5'd0, r_out_used, r_out_offset, r_out_index};

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_head_valid = r_head_valid;
        n_fresh      = r_fresh;
        n_in_use     = r_in_use;
        n_slot       = r_slot;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_index  = r_out_index;
        n_out_offset = r_out_offset;
        n_out_used   = r_out_used;
        n_out_status = r_out_status;
        mem_we       = 1'b0;
        mem_waddr    = AW'(in_idx);
        mem_wdata    = r_head_valid ? LW'(r_head) : LINK_END;
        mem_re       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_slot   = '0;
                    n_status = ST_OK;
                    n_state  = S_MUL;
                    if (in_op == OP_RELEASE) begin
                        if (r_in_use == '0) begin
                            n_status = ST_NONE_USED;
                        end else if (CNT_W'(in_idx) >= eff_count) begin
                            n_status = ST_RANGE;
                        end else begin
                            mem_we       = 1'b1;
                            n_head       = AW'(in_idx);
                            n_head_valid = 1'b1;
                            n_in_use     = r_in_use - CNT_W'(1);
                        end
                    end else if (r_head_valid) begin
                        // link of the head slot arrives next cycle
                        mem_re  = 1'b1;
                        n_slot  = r_head;
                        n_state = S_POP;
                    end else if (r_fresh < eff_count) begin
                        n_slot   = AW'(r_fresh);
                        n_fresh  = r_fresh + CNT_W'(1);
                        n_in_use = r_in_use + CNT_W'(1);
                    end else begin
                        n_status = ST_EMPTY;
                    end
                end
            end
            S_POP: begin
                if (mem_rdata < LINK_END) begin
                    n_head = AW'(mem_rdata);
                end else begin
                    n_head_valid = 1'b0;
                end
                n_in_use = r_in_use + CNT_W'(1);
                n_state  = S_MUL;
            end
            S_MUL: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_index  = IDX_W'(r_slot);
                    n_out_offset = OFS_W'(slot_ofs);
                    n_out_used   = r_in_use;
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cfg_restart) begin
            n_head_valid = 1'b0;
            n_fresh      = '0;
            n_in_use     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pool_count <= POOL_COUNT_RST;
            r_elem_size  <= ELEM_SIZE_RST;
            r_align_log2 <= ALIGN_LOG2_RST;
            r_head_valid <= 1'b0;
            r_fresh      <= '0;
            r_in_use     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head_valid <= n_head_valid;
            r_fresh      <= n_fresh;
            r_in_use     <= n_in_use;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_POOL_COUNT: r_pool_count <= i_cfg_data[CNT_W-1:0];
                    CFG_ELEM_SIZE:  r_elem_size  <= i_cfg_data[ESZ_W-1:0];
                    CFG_ALIGN_LOG2: r_align_log2 <= i_cfg_data[ALN_W-1:0];
                    default: ;
                endcase
            end
        end
        r_head       <= n_head;
        r_slot       <= n_slot;
        r_status     <= n_status;
        r_out_index  <= n_out_index;
        r_out_offset <= n_out_offset;
        r_out_used   <= n_out_used;
        r_out_status <= n_out_status;
    end

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while output stalled");

    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= eff_count)
        else $error("fresh counter above pool count");

    a_pop_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> r_head_valid)
        else $error("free list pop with empty list");

    a_release_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_op == OP_RELEASE && n_status == ST_OK && !i_cfg_we)
        |=> (r_in_use == $past(r_in_use) - CNT_W'(1)) && r_head_valid)
        else $error("release did not update pool state");

    a_result_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_out_valid && !m_axis_tready) |=> (r_state == S_MUL))
        else $error("result dropped while output stalled");
`endif

endmodule

/* sim/tb_fixed_pool_free_list_allocator_unit.sv */
`timescale 1ns / 1ps

module tb_fixed_pool_free_list_allocator_unit;
    import fpfl_pkg::*;

    localparam int POOL_SLOTS     = 1024;
    localparam int POINTER_BYTES  = 8;
    localparam logic [CNT_W-1:0] LINK_END = 11'd1024;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } t_rx_mode;

    typedef struct packed {
        t_status            status;
        logic [IDX_W-1:0]   granted;
        logic [OFS_W-1:0]   offset;
        logic [CNT_W-1:0]   used;
    } t_grant_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;   // [9:0] slot_index
    logic                   s_axis_tuser;   // [0] opcode
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [9:0] granted_index, [31:10] byte_offset, [42:32] used_count
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [1:0]             m_axis_tuser;   // [1:0] status

    fixed_pool_free_list_allocator_unit #(
        .POOL_SLOTS    (POOL_SLOTS),
        .POINTER_BYTES (POINTER_BYTES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [CNT_W-1:0]   m_link [POOL_SLOTS];
    logic [IDX_W-1:0]   m_head;
    bit                 m_head_valid;
    int unsigned        m_fresh;
    int unsigned        m_in_use;
    int unsigned        m_pool_count;
    int unsigned        m_elem_size;
    int unsigned        m_align_log2;

    t_grant_result      expected_grants[$];
    logic [IDX_W-1:0]   granted_slots[$];   // slots currently handed out
    int                 errors = 0;

    // stimulus control
    t_rx_mode           rx_mode = RX_ALWAYS;
    bit                 tx_gaps = 1'b1;
    int                 burst_left = 0;
    bit                 hold_req = 1'b0;
    int                 hold_left = 0;
    int unsigned        rx_tick = 0;
    int                 stall_cycles = 0;

    function automatic int unsigned eff_count();
        return (m_pool_count > POOL_SLOTS) ? POOL_SLOTS : m_pool_count;
    endfunction

    task automatic restart_pool();
        m_head       = '0;
        m_head_valid = 1'b0;
        m_fresh      = 0;
        m_in_use     = 0;
        granted_slots.delete();
    endtask

    task automatic predict_grant(input t_op op, input logic [IDX_W-1:0] idx);
        t_grant_result      r;
        logic [IDX_W-1:0]   slot;
        longint unsigned    sz;
        longint unsigned    mask;
        bit                 ok;
        int                 pos[$];
        r    = '{ST_OK, '0, '0, '0};
        slot = '0;
        ok   = 1'b1;
        if (op == OP_ALLOC) begin
            if (m_head_valid) begin
                slot = m_head;
                if (m_link[slot] < LINK_END)
                    m_head = m_link[slot][IDX_W-1:0];
                else
                    m_head_valid = 1'b0;
            end else if (m_fresh < eff_count()) begin
                slot = IDX_W'(m_fresh);
                m_fresh++;
            end else begin
                ok = 1'b0;
                r.status = ST_EMPTY;
            end
            if (ok) begin
                m_in_use++;
                sz   = (m_elem_size < POINTER_BYTES) ? POINTER_BYTES : m_elem_size;
                mask = (64'd1 << m_align_log2) - 1;
                sz   = (sz + mask) & ~mask;
                r.granted = slot;
                r.offset  = OFS_W'(slot * sz);
                granted_slots.push_back(slot);
            end
        end else if (m_in_use == 0) begin
            r.status = ST_NONE_USED;
        end else if (idx >= eff_count()) begin
            r.status = ST_RANGE;
        end else begin
            m_link[idx]  = m_head_valid ? {1'b0, m_head} : LINK_END;
            m_head       = idx;
            m_head_valid = 1'b1;
            m_in_use--;
            pos = granted_slots.find_first_index(s) with (s == idx);
            if (pos.size() != 0)
                granted_slots.delete(pos[0]);
        end
        r.used = CNT_W'(m_in_use);
        expected_grants.push_back(r);
    endtask

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // result checker, request tracker and watchdog
    always @(posedge i_clk) begin
        t_grant_result want;
        bit            s_hs;
        bit            m_hs;
        if (i_rst_n) begin
            m_hs = m_axis_tvalid && m_axis_tready;
            s_hs = s_axis_tvalid && s_axis_tready;
            if (m_hs) begin
                if (expected_grants.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: expected none, actual status %0d data %h",
                             $time, m_axis_tuser, m_axis_tdata);
                end else begin
                    want = expected_grants.pop_front();
                    check_field("status", want.status, m_axis_tuser);
                    check_field("granted_index", want.granted, m_axis_tdata[9:0]);
                    check_field("byte_offset", want.offset, m_axis_tdata[31:10]);
                    check_field("used_count", want.used, m_axis_tdata[42:32]);
                end
            end
            if (s_hs)
                predict_grant(t_op'(s_axis_tuser), s_axis_tdata[IDX_W-1:0]);
            if (s_hs || m_hs)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, stall_cycles);
                $display("tb_fixed_pool_free_list_allocator_unit: FAIL");
                $finish;
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            rx_tick++;
            case (rx_mode)
                RX_ALWAYS:  m_axis_tready <= 1'b1;
                RX_RANDOM:  m_axis_tready <= ($urandom_range(99) < 60);
                default:    m_axis_tready <= ((rx_tick % 7) < 4);
            endcase
        end
    end

    // called at a falling edge, returns at a falling edge after the item is taken
    task automatic send_request(input t_op op, input logic [IDX_W-1:0] idx);
        int gap;
        gap = 0;
        if (tx_gaps) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_DATA_W-IDX_W){1'b0}}, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_grants.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx which, input int unsigned value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data  <= CFG_W'(value);
        @(posedge i_clk);
        case (which)
            CFG_POOL_COUNT: begin
                m_pool_count = value & 'h7FF;
                restart_pool();
            end
            CFG_ELEM_SIZE:  m_elem_size  = value & 'h1FFF;
            CFG_ALIGN_LOG2: m_align_log2 = value & 'hF;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(input int unsigned count, input int unsigned esz,
                             input int unsigned aln);
        wait_idle();
        write_reg(CFG_POOL_COUNT, count);
        write_reg(CFG_ELEM_SIZE, esz);
        write_reg(CFG_ALIGN_LOG2, aln);
    endtask

    // mostly well-formed traffic: releases of handed-out slots, plus junk indexes
    task automatic run_random(input int n);
        int                 alloc_pct;
        int                 r;
        t_op                op;
        logic [IDX_W-1:0]   idx;
        alloc_pct = 50;
        for (int i = 0; i < n; i++) begin
            if (i % 16 == 0) begin
                r = $urandom_range(2);
                alloc_pct = (r == 0) ? 80 : (r == 1) ? 25 : 50;
            end
            idx = IDX_W'($urandom_range(1023));
            if ($urandom_range(99) < alloc_pct) begin
                op = OP_ALLOC;
            end else begin
                op = OP_RELEASE;
                r  = $urandom_range(99);
                if (r < 80 && granted_slots.size() != 0)
                    idx = granted_slots[$urandom_range(granted_slots.size() - 1)];
                else if (r >= 90)
                    idx = IDX_W'(eff_count() + $urandom_range(1) - 1);
            end
            send_request(op, idx);
        end
    endtask

    task automatic test_release_when_empty();
        rx_mode = RX_ALWAYS;
        send_request(OP_RELEASE, 10'd0);
        send_request(OP_RELEASE, 10'h3FF);
    endtask

    task automatic test_fresh_then_lifo();
        configure(3, 8, 3);
        rx_mode = RX_RANDOM;
        repeat (4) send_request(OP_ALLOC, 10'h3FF);   // 0, 1, 2, then empty
        send_request(OP_RELEASE, 10'd3);              // out of range
        send_request(OP_RELEASE, 10'd2);
        send_request(OP_RELEASE, 10'd0);
        repeat (3) send_request(OP_ALLOC, 10'd0);     // 0, 2 back to back, then empty
        send_request(OP_RELEASE, 10'd1);
        send_request(OP_RELEASE, 10'd1);              // double release is pushed as given
        send_request(OP_ALLOC, 10'd0);
    endtask

    task automatic test_offset_extremes();
        configure(1024, 8191, 15);
        send_request(OP_ALLOC, 10'd0);
        send_request(OP_RELEASE, 10'h3FF);            // slot never handed out
        send_request(OP_ALLOC, 10'd0);                // offset wraps
        wait_idle();
        write_reg(CFG_ELEM_SIZE, 1);                  // below pointer size
        write_reg(CFG_ALIGN_LOG2, 0);
        send_request(OP_RELEASE, 10'h3FF);
        send_request(OP_ALLOC, 10'd0);
    endtask

    task automatic test_count_limits();
        configure(0, 4096, 12);
        send_request(OP_ALLOC, 10'd0);
        send_request(OP_RELEASE, 10'd5);
        wait_idle();
        write_reg(CFG_UNUSED, 13'h1FFF);
        write_reg(CFG_POOL_COUNT, 2047);              // clamps to the slot count
        send_request(OP_ALLOC, 10'd0);
    endtask

    task automatic test_random_phase(input int unsigned count, input int unsigned esz,
                                     input int unsigned aln, input t_rx_mode rx,
                                     input bit gaps, input int n);
        configure(count, esz, aln);
        rx_mode = rx;
        tx_gaps = gaps;
        run_random(n);
    endtask

    // slot size changes must not restart the pool
    task automatic test_size_change();
        test_random_phase(20, 24, 2, RX_RANDOM, 1'b1, 60);
        wait_idle();
        write_reg(CFG_ELEM_SIZE, 100);
        write_reg(CFG_ALIGN_LOG2, 5);
        run_random(60);
    endtask

    task automatic test_output_backpressure();
        configure(64, 8, 3);
        rx_mode  = RX_ALWAYS;
        tx_gaps  = 1'b0;
        hold_req = 1'b1;
        run_random(40);
        tx_gaps  = 1'b1;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_POOL_COUNT;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ALLOC;
        m_axis_tready = 1'b0;
        m_pool_count  = POOL_COUNT_RST;
        m_elem_size   = ELEM_SIZE_RST;
        m_align_log2  = ALIGN_LOG2_RST;
        restart_pool();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_release_when_empty();
        test_fresh_then_lifo();
        test_offset_extremes();
        test_count_limits();
        test_random_phase(16, 8, 3, RX_RANDOM, 1'b1, 120);
        test_random_phase(2047, $urandom_range(1, 8191), $urandom_range(15),
                          RX_PATTERN, 1'b0, 120);
        test_random_phase(1, 1, 0, RX_ALWAYS, 1'b1, 60);
        test_random_phase(64, 4096, 12, RX_RANDOM, 1'b1, 100);
        test_size_change();
        test_output_backpressure();
        test_random_phase($urandom_range(1024), $urandom_range(1, 8191), $urandom_range(15),
                          RX_RANDOM, 1'b1, 100);

        wait_idle();
        repeat (20) @(negedge i_clk);
        if (expected_grants.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, expected_grants.size());
        end
        if (errors == 0)
            $display("tb_fixed_pool_free_list_allocator_unit: PASS");
        else
            $display("tb_fixed_pool_free_list_allocator_unit: FAIL");
        $finish;
    end

endmodule

/* fixed_pool_free_list_allocator_unit.f */
rtl/fpfl_pkg.sv
rtl/fpfl_ram.sv
rtl/fixed_pool_free_list_allocator_unit.sv
sim/tb_fixed_pool_free_list_allocator_unit.sv
